@@ hw/rtl/ipv4_lpt_pkg.sv @@
// Shared types, codes and helpers for the IPv4 longest-prefix route table.
// Used by ipv4_lpt_ctrl, ipv4_lpt_dp, ipv4_longest_prefix_table_core and tb_top.
// No dependencies.
package ipv4_lpt_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam logic [5:0] MAX_LEN = 6'd32;

	typedef enum logic [1:0] {
		FN_LPM    = 2'd0,
		FN_EXACT  = 2'd1,
		FN_INSERT = 2'd2,
		FN_REMOVE = 2'd3
	} func_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// one table slot as held in the memory
	typedef struct packed {
		logic        valid;
		logic [31:0] prefix;
		logic [5:0]  length;
		logic [31:0] value;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_wr;   // clearing pass: write an empty slot at the counter
		logic capture;  // latch a new transaction, restart the counter
		logic rd_en;    // scan read at the counter
		logic finish;   // commit table update and load the result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cnt_last;
		logic cnt_zero;
	} sts_t;

	function automatic logic [31:0] mask_of(input logic [5:0] len);
		logic [31:0] ones;
		ones = '1;
		if (len == 6'd0) begin
			return 32'd0;
		end
		return ones << (MAX_LEN - len);
	endfunction

endpackage

@@ hw/rtl/ipv4_lpt_ctrl.sv @@
// Sequencer for the route table: clearing pass, scan, finish, result handoff.
// Depends on ipv4_lpt_pkg (cmd_t, sts_t).
module ipv4_lpt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output ipv4_lpt_pkg::cmd_t  cmd,
	input  ipv4_lpt_pkg::sts_t  sts
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_busy;

	assign out_busy  = out_valid_q && out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.clr_wr  = (state_q == S_CLEAR);
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.rd_en   = (state_q == S_SCAN);
		cmd.finish  = (state_q == S_FINISH) && !out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !cmd.finish) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (sts.cnt_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.cnt_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_busy) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_valid_q && out_stall))
		else $error("result loaded while previous one still held");

	// every transaction starts its scan at slot zero
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> sts.cnt_zero)
		else $error("transaction accepted with scan counter not at zero");

	// a scan covers the whole table before the finish step
	a_drain_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> $past(cmd.rd_en && sts.cnt_last))
		else $error("drain entered without reading the last slot");

endmodule

@@ hw/rtl/ipv4_lpt_dp.sv @@
// Datapath of the route table: slot memory, scan counter, match evaluation,
// best-match tracking and result registers. Depends on ipv4_lpt_pkg.
module ipv4_lpt_dp #(
	parameter int TABLE_ENTRIES = ipv4_lpt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ipv4_lpt_pkg::cmd_t  cmd,
	output ipv4_lpt_pkg::sts_t  sts,
	input  logic [1:0]          func,
	input  logic [31:0]         address,
	input  logic [5:0]          prefix_len,
	input  logic [31:0]         entry_value,
	output logic                hit,
	output logic [31:0]         found_value,
	output logic [5:0]          found_len,
	output logic [1:0]          status
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	ipv4_lpt_pkg::entry_t mem [TABLE_ENTRIES];

	logic [IDX_W-1:0] cnt_q;
	logic             eval_s1;
	ipv4_lpt_pkg::entry_t rdata_s1;
	logic [IDX_W-1:0] ridx_s1;

	ipv4_lpt_pkg::func_t op_q;
	logic [31:0] addr_q;
	logic [31:0] key_q;
	logic [5:0]  len_q;
	logic [31:0] val_q;

	logic        best_found_q;
	logic [5:0]  best_len_q;
	logic [31:0] best_val_q;
	logic        match_found_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [31:0] match_val_q;
	logic        free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	logic [5:0]  len_sat;
	logic        lpm_ok;
	logic        exact_ok;
	logic        wr_en;
	logic [IDX_W-1:0] wr_idx;
	ipv4_lpt_pkg::entry_t wr_data;
	logic        do_insert;
	logic        do_remove;

	assign sts.cnt_last = (cnt_q == LAST_IDX);
	assign sts.cnt_zero = (cnt_q == '0);

	assign len_sat = (prefix_len > ipv4_lpt_pkg::MAX_LEN) ? ipv4_lpt_pkg::MAX_LEN : prefix_len;

	assign lpm_ok = rdata_s1.valid && (rdata_s1.length <= len_q)
		&& ((addr_q & ipv4_lpt_pkg::mask_of(rdata_s1.length)) == rdata_s1.prefix);
	assign exact_ok = rdata_s1.valid && (rdata_s1.length == len_q)
		&& (rdata_s1.prefix == key_q);

	assign do_insert = (op_q == ipv4_lpt_pkg::FN_INSERT) && !match_found_q && free_found_q;
	assign do_remove = (op_q == ipv4_lpt_pkg::FN_REMOVE) && match_found_q;

	always_comb begin
		wr_en   = cmd.clr_wr || (cmd.finish && (do_insert || do_remove));
		wr_idx  = cmd.clr_wr ? cnt_q : (do_insert ? free_idx_q : match_idx_q);
		wr_data = '0;
		if (!cmd.clr_wr && do_insert) begin
			wr_data.valid  = 1'b1;
			wr_data.prefix = key_q;
			wr_data.length = len_q;
			wr_data.value  = val_q;
		end
	end

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[cnt_q];
			ridx_s1  <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			eval_s1 <= 1'b0;
		end else begin
			eval_s1 <= cmd.rd_en;
			if (cmd.capture) begin
				cnt_q <= '0;
			end else if (cmd.clr_wr || cmd.rd_en) begin
				cnt_q <= sts.cnt_last ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q          <= ipv4_lpt_pkg::func_t'(func);
			addr_q        <= address;
			len_q         <= len_sat;
			key_q         <= address & ipv4_lpt_pkg::mask_of(len_sat);
			val_q         <= entry_value;
			best_found_q  <= 1'b0;
			best_len_q    <= '0;
			best_val_q    <= '0;
			match_found_q <= 1'b0;
			match_idx_q   <= '0;
			match_val_q   <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
		end else if (eval_s1) begin
			// strict compare keeps the lowest slot on equal lengths
			if (lpm_ok && (!best_found_q || rdata_s1.length > best_len_q)) begin
				best_found_q <= 1'b1;
				best_len_q   <= rdata_s1.length;
				best_val_q   <= rdata_s1.value;
			end
			if (exact_ok && !match_found_q) begin
				match_found_q <= 1'b1;
				match_idx_q   <= ridx_s1;
				match_val_q   <= rdata_s1.value;
			end
			if (!rdata_s1.valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= ridx_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			case (op_q)
				ipv4_lpt_pkg::FN_LPM: begin
					hit         <= best_found_q;
					found_value <= best_val_q;
					found_len   <= best_len_q;
					status      <= ipv4_lpt_pkg::ST_OK;
				end
				ipv4_lpt_pkg::FN_EXACT: begin
					hit         <= match_found_q;
					found_value <= match_val_q;
					found_len   <= match_found_q ? len_q : 6'd0;
					status      <= ipv4_lpt_pkg::ST_OK;
				end
				ipv4_lpt_pkg::FN_INSERT: begin
					hit         <= 1'b0;
					found_value <= '0;
					found_len   <= '0;
					if (match_found_q) begin
						status <= ipv4_lpt_pkg::ST_DUP;
					end else if (!free_found_q) begin
						status <= ipv4_lpt_pkg::ST_FULL;
					end else begin
						status <= ipv4_lpt_pkg::ST_OK;
					end
				end
				default: begin
					hit         <= 1'b0;
					found_value <= '0;
					found_len   <= '0;
					status      <= ipv4_lpt_pkg::ST_OK;
				end
			endcase
		end
	end

	// stored lengths are always saturated
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(eval_s1 && rdata_s1.valid) |-> (rdata_s1.length <= ipv4_lpt_pkg::MAX_LEN))
		else $error("stored prefix length out of range");

	// the clearing pass and a scan never overlap
	a_clr_vs_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !(cmd.rd_en || eval_s1 || cmd.finish))
		else $error("clearing write during a scan");

endmodule

@@ hw/rtl/ipv4_longest_prefix_table_core.sv @@
// IPv4 longest-prefix route table, top level.
// Instantiates ipv4_lpt_ctrl and ipv4_lpt_dp; depends on ipv4_lpt_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per transaction:
//   func selects longest-prefix lookup, exact lookup, insert or remove;
//   prefix_len above 32 is treated as 32.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   operation: hit, found_value, found_len, status.
//   Every operation scans all TABLE_ENTRIES slots of the slot memory, one
//   slot per cycle. A result is offered after the scan, the read drain and
//   the finish step; the block then returns to idle, and it takes no new
//   transaction until the one before it has been through all these steps.
//   After reset, a clearing pass over all TABLE_ENTRIES slots empties the
//   memory; in_stall stays high during it.
//   A finished result sits in an output register; the next operation is
//   accepted and scanned meanwhile. If out_stall still holds the earlier
//   result when the next one is done, the block waits in its finish step
//   with in_stall high until the output is taken.
module ipv4_longest_prefix_table_core #(
	parameter int TABLE_ENTRIES = ipv4_lpt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] address,
	input  logic [5:0]  prefix_len,
	input  logic [31:0] entry_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [31:0] found_value,
	output logic [5:0]  found_len,
	output logic [1:0]  status
);

	ipv4_lpt_pkg::cmd_t cmd;
	ipv4_lpt_pkg::sts_t sts;

	ipv4_lpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	ipv4_lpt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (func),
		.address     (address),
		.prefix_len  (prefix_len),
		.entry_value (entry_value),
		.hit         (hit),
		.found_value (found_value),
		.found_len   (found_len),
		.status      (status)
	);

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for ipv4_longest_prefix_table_core: directed table, then random
// route operations checked against an in-bench route table predictor.
// Depends on ipv4_lpt_pkg and ipv4_longest_prefix_table_core.
`timescale 1ns / 100ps

module tb_top;

	localparam ipv4_lpt_pkg::func_t FN_LPM    = ipv4_lpt_pkg::FN_LPM;
	localparam ipv4_lpt_pkg::func_t FN_EXACT  = ipv4_lpt_pkg::FN_EXACT;
	localparam ipv4_lpt_pkg::func_t FN_INSERT = ipv4_lpt_pkg::FN_INSERT;
	localparam ipv4_lpt_pkg::func_t FN_REMOVE = ipv4_lpt_pkg::FN_REMOVE;
	localparam logic [1:0] ST_OK   = ipv4_lpt_pkg::ST_OK;
	localparam logic [1:0] ST_DUP  = ipv4_lpt_pkg::ST_DUP;
	localparam logic [1:0] ST_FULL = ipv4_lpt_pkg::ST_FULL;
	localparam logic [5:0] MAX_LEN = ipv4_lpt_pkg::MAX_LEN;

	localparam int TBL_DEPTH = ipv4_lpt_pkg::TABLE_ENTRIES_DEF;
	localparam int POOL_SIZE = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 90;
	localparam int DIR_ROWS = 22;

	typedef struct packed {
		ipv4_lpt_pkg::func_t fn;
		logic [31:0] addr;
		logic [5:0]  len;
		logic [31:0] value;
	} route_op_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] value;
		logic [5:0]  len;
		logic [1:0]  status;
	} route_rsp_t;

	typedef struct packed {
		route_op_t  op;
		logic       typed;
		route_rsp_t rsp;
	} dir_row_t;

	// typed rows carry their result; the rest are checked by the predictor
	localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
		'{'{FN_LPM,    32'hFFFF_FFFF, 6'd32, 32'h0000_0000}, 1'b1, '{1'b0, 32'h0, 6'd0, ST_OK}},
		'{'{FN_EXACT,  32'h0000_0000, 6'd0,  32'h0000_0000}, 1'b1, '{1'b0, 32'h0, 6'd0, ST_OK}},
		'{'{FN_REMOVE, 32'h1234_5678, 6'd24, 32'h0000_0000}, 1'b1, '{1'b0, 32'h0, 6'd0, ST_OK}},
		'{'{FN_INSERT, 32'h0000_0000, 6'd0,  32'hFFFF_FFFF}, 1'b1, '{1'b0, 32'h0, 6'd0, ST_OK}},
		'{'{FN_INSERT, 32'hDEAD_BEEF, 6'd0,  32'h0000_0005}, 1'b1, '{1'b0, 32'h0, 6'd0, ST_DUP}},
		'{'{FN_LPM,    32'h0A00_0001, 6'd32, 32'h0000_0000}, 1'b1,
			'{1'b1, 32'hFFFF_FFFF, 6'd0, ST_OK}},
		'{'{FN_INSERT, 32'h0A12_3456, 6'd8,  32'h0000_0001}, 1'b1, '{1'b0, 32'h0, 6'd0, ST_OK}},
		'{'{FN_INSERT, 32'h0A01_FFFF, 6'd16, 32'h0000_0002}, 1'b1, '{1'b0, 32'h0, 6'd0, ST_OK}},
		'{'{FN_INSERT, 32'h0A01_0203, 6'd32, 32'h0000_0003}, 1'b1, '{1'b0, 32'h0, 6'd0, ST_OK}},
		'{'{FN_LPM,    32'h0A01_0203, 6'd32, 32'h0000_0000}, 1'b1, '{1'b1, 32'h3, 6'd32, ST_OK}},
		'{'{FN_LPM,    32'h0A01_0203, 6'd31, 32'h0000_0000}, 1'b0, '0},
		'{'{FN_LPM,    32'h0A01_0203, 6'd63, 32'h0000_0000}, 1'b0, '0},
		'{'{FN_EXACT,  32'h0A01_ABCD, 6'd16, 32'hA5A5_A5A5}, 1'b1, '{1'b1, 32'h2, 6'd16, ST_OK}},
		'{'{FN_EXACT,  32'h0A01_0000, 6'd15, 32'h0000_0000}, 1'b0, '0},
		'{'{FN_REMOVE, 32'h0A01_ABCD, 6'd16, 32'h0000_0000}, 1'b1, '{1'b0, 32'h0, 6'd0, ST_OK}},
		'{'{FN_LPM,    32'h0A01_FFFF, 6'd32, 32'h0000_0000}, 1'b0, '0},
		'{'{FN_REMOVE, 32'h0000_0000, 6'd63, 32'h0000_0000}, 1'b0, '0},
		'{'{FN_INSERT, 32'hFFFF_FFFF, 6'd63, 32'h0000_0000}, 1'b0, '0},
		'{'{FN_EXACT,  32'hFFFF_FFFF, 6'd32, 32'h0000_0000}, 1'b0, '0},
		'{'{FN_LPM,    32'hC0A8_0101, 6'd32, 32'h0000_0000}, 1'b0, '0},
		'{'{FN_REMOVE, 32'h0000_0000, 6'd0,  32'h0000_0000}, 1'b1, '{1'b0, 32'h0, 6'd0, ST_OK}},
		'{'{FN_LPM,    32'hC0A8_0101, 6'd32, 32'h0000_0000}, 1'b1, '{1'b0, 32'h0, 6'd0, ST_OK}}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [31:0] address;
	logic [5:0]  prefix_len;
	logic [31:0] entry_value;
	logic        out_valid;
	logic        out_stall;
	logic        hit;
	logic [31:0] found_value;
	logic [5:0]  found_len;
	logic [1:0]  status;

	// predictor copy of the route table
	bit          route_valid [TBL_DEPTH];
	logic [31:0] route_prefix [TBL_DEPTH];
	logic [5:0]  route_len [TBL_DEPTH];
	logic [31:0] route_value [TBL_DEPTH];

	route_rsp_t  pending_rsp [$];
	logic [31:0] addr_pool [POOL_SIZE];
	int          err_cnt = 0;
	int          snd_idle_pct = 0;
	int          rcv_stall_pct = 0;
	int          hold_seq = 0;

	ipv4_longest_prefix_table_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.address     (address),
		.prefix_len  (prefix_len),
		.entry_value (entry_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.found_value (found_value),
		.found_len   (found_len),
		.status      (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] len_mask(input logic [5:0] len);
		return (len == 6'd0) ? 32'd0 : ~(32'hFFFF_FFFF >> len);
	endfunction

	// applies one operation to the predictor table and returns its result
	function automatic route_rsp_t route_apply(input route_op_t op);
		route_rsp_t r;
		logic [5:0]  len;
		logic [31:0] key;
		int          slot;
		int          free_slot;
		r = '0;
		len = (op.len > MAX_LEN) ? MAX_LEN : op.len;
		key = op.addr & len_mask(len);
		slot = -1;
		free_slot = -1;
		for (int i = 0; i < TBL_DEPTH; i++) begin
			if (!route_valid[i]) begin
				if (free_slot < 0)
					free_slot = i;
			end else if (op.fn == FN_LPM) begin
				if (route_len[i] <= len && (op.addr & len_mask(route_len[i])) == route_prefix[i]
						&& (slot < 0 || route_len[i] > route_len[slot]))
					slot = i;
			end else if (route_len[i] == len && route_prefix[i] == key && slot < 0) begin
				slot = i;
			end
		end
		case (op.fn)
			FN_LPM, FN_EXACT: begin
				if (slot >= 0) begin
					r.hit = 1'b1;
					r.value = route_value[slot];
					r.len = route_len[slot];
				end
			end
			FN_INSERT: begin
				if (slot >= 0) begin
					r.status = ST_DUP;
				end else if (free_slot < 0) begin
					r.status = ST_FULL;
				end else begin
					route_valid[free_slot] = 1'b1;
					route_prefix[free_slot] = key;
					route_len[free_slot] = len;
					route_value[free_slot] = op.value;
				end
			end
			default: begin
				if (slot >= 0)
					route_valid[slot] = 1'b0;
			end
		endcase
		return r;
	endfunction

	// random operation; often aimed at a live route so lookups and removes hit
	function automatic route_op_t pick_op(input int ins_w, input int rem_w, input int lpm_w);
		route_op_t   op;
		int          r;
		int          live;
		int          probe;
		logic [31:0] host_bits;
		r = $urandom_range(0, 99);
		live = -1;
		for (int k = 0; k < 8 && live < 0; k++) begin
			probe = $urandom_range(0, TBL_DEPTH - 1);
			if (route_valid[probe])
				live = probe;
		end
		op.value = $urandom_range(0, 32'hFFFF_FFFE);
		op.addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)] ^ ($urandom >> $urandom_range(4, 32));
		if ($urandom_range(0, 9) == 0)
			op.addr = $urandom;
		case ($urandom_range(0, 9))
			0: op.len = 6'($urandom_range(33, 63));
			1, 2, 3: op.len = 6'($urandom_range(0, 32));
			default: op.len = 6'($urandom_range(0, 8) * 4);
		endcase
		host_bits = (live >= 0) ? ($urandom & ~len_mask(route_len[live])) : 32'd0;
		if (r < ins_w) begin
			op.fn = FN_INSERT;
			if (live >= 0 && $urandom_range(0, 99) < 15) begin
				op.addr = route_prefix[live] | host_bits;
				op.len = route_len[live];
			end
		end else if (r < ins_w + rem_w) begin
			op.fn = FN_REMOVE;
			if (live >= 0 && $urandom_range(0, 99) < 70) begin
				op.addr = route_prefix[live] | host_bits;
				op.len = route_len[live];
			end
		end else if (r < ins_w + rem_w + lpm_w) begin
			op.fn = FN_LPM;
			if (live >= 0 && $urandom_range(0, 1) == 1) begin
				op.addr = route_prefix[live] | host_bits;
				op.len = 6'($urandom_range(route_len[live], 32));
			end
		end else begin
			op.fn = FN_EXACT;
			if (live >= 0 && $urandom_range(0, 1) == 1) begin
				op.addr = route_prefix[live] | host_bits;
				op.len = route_len[live];
			end
		end
		return op;
	endfunction

	task automatic send_op(input route_op_t op, input bit use_typed, input route_rsp_t typed_rsp);
		route_rsp_t predicted;
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op.fn;
		address <= op.addr;
		prefix_len <= op.len;
		entry_value <= op.value;
		do
			@(posedge clk);
		while (in_stall);
		// transaction accepted at this edge
		predicted = route_apply(op);
		pending_rsp.push_back(use_typed ? typed_rsp : predicted);
	endtask

	task automatic run_phase(input int n, input int idle_pct, input int stall_pct,
			input int ins_w, input int rem_w, input int lpm_w);
		snd_idle_pct = idle_pct;
		rcv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++)
			send_op(pick_op(ins_w, rem_w, lpm_w), 1'b0, '0);
	endtask

	task automatic field_check(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// result side: check on acceptance, then pick the next stall value
	initial begin
		route_rsp_t want;
		int         hold_left;
		int         hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_rsp.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result, expected none, %s %0b %0h %0d %0d",
						$time, "got hit/value/len/status", hit, found_value,
						found_len, status);
				end else begin
					want = pending_rsp.pop_front();
					field_check("hit", 32'(want.hit), 32'(hit));
					field_check("found_value", want.value, found_value);
					field_check("found_len", 32'(want.len), 32'(found_len));
					field_check("status", 32'(want.status), 32'(status));
				end
			end
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FN_LPM;
		address = 32'd0;
		prefix_len = 6'd0;
		entry_value = 32'd0;
		foreach (addr_pool[i])
			addr_pool[i] = $urandom;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++)
			send_op(DIR_TBL[i].op, DIR_TBL[i].typed, DIR_TBL[i].rsp);

		// fill to full, mixed traffic under both kinds of idling, drain, then refill behind a long output stall
		run_phase(260, 0, 0, 60, 5, 25);
		run_phase(200, 78, 0, 30, 25, 30);
		run_phase(200, 0, 78, 30, 25, 30);
		run_phase(150, 26, 26, 10, 55, 25);
		hold_seq++;
		run_phase(130, 0, 0, 50, 10, 30);
		in_valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// watchdog on simulated time; a clean run needs well under a tenth of it
	initial begin
		#10_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/ipv4_lpt_pkg.sv
hw/rtl/ipv4_lpt_ctrl.sv
hw/rtl/ipv4_lpt_dp.sv
hw/rtl/ipv4_longest_prefix_table_core.sv
dv/tb_top.sv
